>>> sv/cepq_pkg.sv
// Shared types and codes for the coalescing priority event queue.
// No dependencies; imported by the entry cell and the top level.
package cepq_pkg;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_COALESCED = 3'd1;
    localparam logic [2:0] ST_DROPPED   = 3'd2;
    localparam logic [2:0] ST_POPPED    = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic        action;
        logic [2:0]  priority_req;
        logic [2:0]  msg_type;
        logic [15:0] item_id;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  out_priority;
        logic [2:0]  out_type;
        logic [15:0] out_item_id;
        logic [4:0]  occupancy;
        logic        stay_awake;
    } t_rsp;

    typedef struct packed {
        logic [2:0]  prio;
        logic [2:0]  msg_type;
        logic [15:0] item_id;
    } t_entry;

    typedef struct packed {
        logic   insert;
        logic   pop;
        t_entry entry;
    } t_cell_ctrl;

endpackage

>>> sv/cepq_cell.sv
// One queue slot: holds an entry, compares it against the request and
// shifts toward either neighbor. Depends on cepq_pkg.
module cepq_cell (
    input  logic                   i_clk,
    input  cepq_pkg::t_cell_ctrl   i_ctrl,
    input  logic                   i_occupied,
    input  logic                   i_at_tail,
    input  logic                   i_left_gt,
    input  cepq_pkg::t_entry       i_left_entry,
    input  cepq_pkg::t_entry       i_right_entry,
    output cepq_pkg::t_entry       o_entry,
    output logic                   o_gt,
    output logic                   o_match
);
    import cepq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    assign o_gt    = i_occupied && (r_entry.prio > i_ctrl.entry.prio);
    assign o_match = i_occupied && (r_entry == i_ctrl.entry);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctrl.pop) begin
            n_entry = i_right_entry;
        end else if (i_ctrl.insert) begin
            priority if (i_left_gt) begin
                n_entry = i_left_entry;
            end else if (o_gt || i_at_tail) begin
                n_entry = i_ctrl.entry;
            end else begin
                n_entry = r_entry;
            end
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

>>> sv/coalescing_priority_event_queue.sv
// Coalescing priority event queue: top level with the row of entry cells,
// the fill count, the stay-awake flag and the response register.
// Depends on cepq_pkg and cepq_cell.
//
// Requests enter on i_req (valid/stall): a push carries priority, type and
// item id; a pop takes the head. Entries are ordered by priority, lowest
// first, equal priorities in arrival order. A push equal to a queued entry
// is coalesced; a push into a full queue is dropped.
// Every request yields exactly one response on o_rsp, registered, in the
// cycle after acceptance. Without stalls throughput is one request per
// cycle: every cell compares against the request in parallel and shifts
// in the same cycle. A new request is taken while a response waits, as
// long as the receiver does not stall; when i_rsp_stall holds the pending
// response, o_req_stall rises and the queue holds.
// Reset clears the fill count, the stay-awake flag and the response valid;
// slot contents are not cleared and are never read before being written.
module coalescing_priority_event_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_stall,
    input  cepq_pkg::t_req    i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_stall,
    output cepq_pkg::t_rsp    o_rsp
);
    import cepq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0] r_count, n_count;
    logic          r_awake, n_awake;
    logic          r_rsp_valid;
    t_rsp          r_rsp, n_rsp;

    logic          w_accept;
    logic          w_dup;
    logic          w_full;
    logic          w_empty;
    t_cell_ctrl    w_ctrl;
    t_entry        w_req_entry;
    t_entry        w_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_gt;
    logic [QUEUE_DEPTH-1:0] w_match;
    logic [31:0]   w_cnt_ext;

    assign o_req_stall = r_rsp_valid && i_rsp_stall;
    assign w_accept    = i_req_valid && !o_req_stall;

    assign w_req_entry.prio     = i_req.priority_req;
    assign w_req_entry.msg_type = i_req.msg_type;
    assign w_req_entry.item_id  = i_req.item_id;

    assign w_dup   = |w_match;
    assign w_full  = (r_count == CW'(QUEUE_DEPTH));
    assign w_empty = (r_count == '0);

    assign w_ctrl.entry  = w_req_entry;
    assign w_ctrl.insert = w_accept && (i_req.action == ACT_PUSH) && !w_dup && !w_full;
    assign w_ctrl.pop    = w_accept && (i_req.action == ACT_POP) && !w_empty;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_gt;

        if (g == 0) begin : g_head
            assign w_left    = w_req_entry;
            assign w_left_gt = 1'b0;
        end else begin : g_mid
            assign w_left    = w_entry[g-1];
            assign w_left_gt = w_gt[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_right = w_entry[g];
        end else begin : g_body
            assign w_right = w_entry[g+1];
        end

        cepq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_occupied    (CW'(g) < r_count),
            .i_at_tail     (CW'(g) == r_count),
            .i_left_gt     (w_left_gt),
            .i_left_entry  (w_left),
            .i_right_entry (w_right),
            .o_entry       (w_entry[g]),
            .o_gt          (w_gt[g]),
            .o_match       (w_match[g])
        );
    end

    assign w_cnt_ext = 32'(n_count);

    always_comb begin
        n_count = r_count;
        n_awake = r_awake;
        n_rsp   = '0;
        unique case (i_req.action)
            ACT_PUSH: begin
                n_awake = 1'b1;
                priority if (w_dup) begin
                    n_rsp.status = ST_COALESCED;
                end else if (w_full) begin
                    n_rsp.status = ST_DROPPED;
                end else begin
                    n_rsp.status = ST_INSERTED;
                    n_count      = r_count + CW'(1);
                end
            end
            ACT_POP: begin
                if (w_empty) begin
                    n_rsp.status = ST_EMPTY;
                    n_awake      = 1'b0;
                end else begin
                    n_rsp.status       = ST_POPPED;
                    n_rsp.out_priority = w_entry[0].prio;
                    n_rsp.out_type     = w_entry[0].msg_type;
                    n_rsp.out_item_id  = w_entry[0].item_id;
                    n_count            = r_count - CW'(1);
                end
            end
            default: begin
                n_rsp.status = ST_EMPTY;
            end
        endcase
        n_rsp.occupancy  = w_cnt_ext[4:0];
        n_rsp.stay_awake = n_awake;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_awake     <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_awake     <= n_awake;
                r_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

>>> verif/coalescing_priority_event_queue_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the coalescing priority event queue.
// Drives push and pop requests, predicts every response in place; needs cepq_pkg.
module coalescing_priority_event_queue_tb;

    import cepq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int RAND_ITEMS = 1130;
    localparam int QUIET_FROM = 1000;
    localparam int IDLE_LIMIT = 2000;

    logic clk;
    logic rst_n       = 1'b0;
    logic req_valid   = 1'b0;
    logic req_stall;
    t_req req         = '0;
    logic rsp_valid;
    logic rsp_stall   = 1'b0;
    t_rsp rsp;

    t_entry      queued_events[$];
    logic        awake;
    t_rsp        pending_rsp[$];
    int unsigned mismatches;
    bit          quiet;
    int unsigned stall_left;

    t_req directed_req[$];
    bit   directed_has_rsp[$];
    t_rsp directed_rsp[$];

    coalescing_priority_event_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req_valid(req_valid),
        .o_req_stall(req_stall),
        .i_req      (req),
        .o_rsp_valid(rsp_valid),
        .i_rsp_stall(rsp_stall),
        .o_rsp      (rsp)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic t_rsp apply_event_req(input t_req r);
        t_rsp   res;
        t_entry e;
        int     pos;
        bit     dup;
        int     i;
        res = '0;
        if (r.action == ACT_PUSH) begin
            e.prio     = r.priority_req;
            e.msg_type = r.msg_type;
            e.item_id  = r.item_id;
            awake      = 1'b1;
            dup        = 1'b0;
            for (i = 0; i < queued_events.size(); i++) begin
                if (queued_events[i] == e) begin
                    dup = 1'b1;
                end
            end
            if (dup) begin
                res.status = ST_COALESCED;
            end else if (queued_events.size() >= DEPTH) begin
                res.status = ST_DROPPED;
            end else begin
                pos = queued_events.size();
                for (i = 0; i < queued_events.size(); i++) begin
                    if (queued_events[i].prio > e.prio) begin
                        pos = i;
                        break;
                    end
                end
                queued_events.insert(pos, e);
                res.status = ST_INSERTED;
            end
        end else if (queued_events.size() == 0) begin
            awake      = 1'b0;
            res.status = ST_EMPTY;
        end else begin
            e                = queued_events.pop_front();
            res.status       = ST_POPPED;
            res.out_priority = e.prio;
            res.out_type     = e.msg_type;
            res.out_item_id  = e.item_id;
        end
        res.occupancy  = 5'(queued_events.size());
        res.stay_awake = awake;
        return res;
    endfunction

    function automatic t_req push_of(input int p, input int t, input int id);
        t_req r;
        r.action       = ACT_PUSH;
        r.priority_req = 3'(p);
        r.msg_type     = 3'(t);
        r.item_id      = 16'(id);
        return r;
    endfunction

    function automatic t_req pop_of();
        t_req r;
        r              = '0;
        r.action       = ACT_POP;
        r.priority_req = 3'(7);
        r.msg_type     = 3'(7);
        r.item_id      = 16'hFFFF;
        return r;
    endfunction

    function automatic t_rsp rsp_of(input logic [2:0] st, input int p, input int t,
                                    input int id, input int occ, input logic aw);
        t_rsp r;
        r.status       = st;
        r.out_priority = 3'(p);
        r.out_type     = 3'(t);
        r.out_item_id  = 16'(id);
        r.occupancy    = 5'(occ);
        r.stay_awake   = aw;
        return r;
    endfunction

    task automatic add_row(input t_req r, input bit has_rsp, input t_rsp want);
        directed_req.push_back(r);
        directed_has_rsp.push_back(has_rsp);
        directed_rsp.push_back(want);
    endtask

    task automatic send_req(input t_req r, input bit has_rsp, input t_rsp want);
        t_rsp pred;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!(req_valid && !req_stall));
        pred = apply_event_req(r);
        pending_rsp.push_back(has_rsp ? want : pred);
    endtask

    task automatic drain_rsp();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n || quiet) begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end else begin
            rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        t_rsp want;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: response with none expected, got %p", $time, rsp);
                mismatches++;
            end else begin
                want = pending_rsp.pop_front();
                check_field("status", want.status, rsp.status);
                check_field("out_priority", want.out_priority, rsp.out_priority);
                check_field("out_type", want.out_type, rsp.out_type);
                check_field("out_item_id", want.out_item_id, rsp.out_item_id);
                check_field("occupancy", want.occupancy, rsp.occupancy);
                check_field("stay_awake", want.stay_awake, rsp.stay_awake);
            end
        end
    end

    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin
        t_req        r;
        int          n;
        int          seg_len;
        int          push_pct;
        int          k;
        int          pick;
        mismatches = 0;
        quiet      = 1'b0;
        awake      = 1'b0;

        add_row(pop_of(), 1'b1, rsp_of(ST_EMPTY, 0, 0, 0, 0, 1'b0));
        add_row(push_of(7, 7, 16'hFFFF), 1'b1, rsp_of(ST_INSERTED, 0, 0, 0, 1, 1'b1));
        add_row(push_of(7, 7, 16'hFFFF), 1'b1, rsp_of(ST_COALESCED, 0, 0, 0, 1, 1'b1));
        add_row(push_of(0, 0, 16'h0000), 1'b1, rsp_of(ST_INSERTED, 0, 0, 0, 2, 1'b1));
        add_row(push_of(3, 5, 16'h1234), 1'b0, '0);
        add_row(push_of(3, 5, 16'h1235), 1'b0, '0);
        add_row(push_of(5, 1, 16'h0010), 1'b0, '0);
        add_row(push_of(1, 2, 16'h0020), 1'b0, '0);
        add_row(push_of(6, 3, 16'h0030), 1'b0, '0);
        add_row(push_of(2, 4, 16'h5555), 1'b0, '0);
        add_row(push_of(4, 6, 16'h8000), 1'b0, '0);
        add_row(push_of(0, 7, 16'h7FFF), 1'b0, '0);
        add_row(push_of(7, 0, 16'h0001), 1'b0, '0);
        add_row(push_of(3, 5, 16'h1236), 1'b0, '0);
        add_row(push_of(1, 1, 16'h00FF), 1'b0, '0);
        add_row(push_of(5, 2, 16'hFF00), 1'b0, '0);
        add_row(push_of(6, 6, 16'h0F0F), 1'b0, '0);
        add_row(push_of(4, 3, 16'hC3C3), 1'b0, '0);
        add_row(push_of(2, 1, 16'hAAAA), 1'b1, rsp_of(ST_DROPPED, 0, 0, 0, 16, 1'b1));
        add_row(push_of(7, 7, 16'hFFFF), 1'b1, rsp_of(ST_COALESCED, 0, 0, 0, 16, 1'b1));
        add_row(pop_of(), 1'b1, rsp_of(ST_POPPED, 0, 0, 0, 15, 1'b1));
        add_row(pop_of(), 1'b0, '0);
        add_row(push_of(0, 0, 16'h0000), 1'b0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < directed_req.size(); n++) begin
            send_req(directed_req[n], directed_has_rsp[n], directed_rsp[n]);
        end
        drain_rsp();

        n = 0;
        while (n < RAND_ITEMS) begin
            seg_len = $urandom_range(8, 60);
            case ($urandom_range(0, 2))
                0: push_pct = 85;
                1: push_pct = 50;
                default: push_pct = 15;
            endcase
            for (k = 0; k < seg_len && n < RAND_ITEMS; k++) begin
                if (n >= QUIET_FROM) begin
                    quiet = 1'b1;
                end
                r.action       = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP;
                r.priority_req = 3'($urandom_range(0, 7));
                if ($urandom_range(0, 3) == 0) begin
                    r.msg_type = 3'($urandom_range(0, 7));
                    r.item_id  = 16'($urandom());
                end else begin
                    r.msg_type = 3'($urandom_range(0, 1));
                    r.item_id  = 16'($urandom_range(0, 3));
                end
                if (r.action == ACT_PUSH && queued_events.size() != 0
                        && $urandom_range(0, 5) == 0) begin
                    pick           = $urandom_range(0, queued_events.size() - 1);
                    r.priority_req = queued_events[pick].prio;
                    r.msg_type     = queued_events[pick].msg_type;
                    r.item_id      = queued_events[pick].item_id;
                end
                send_req(r, 1'b0, '0);
                n++;
            end
            if (!quiet && $urandom_range(0, 7) == 0) begin
                drain_rsp();
            end
        end

        req_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/cepq_pkg.sv
sv/cepq_cell.sv
sv/coalescing_priority_event_queue.sv
verif/coalescing_priority_event_queue_tb.sv
